FILE: rtl/oled_page_frame_streamer_macros.svh
// Assertion helpers; build with ASSERT_OFF defined to drop them.
`ifndef OLED_PAGE_FRAME_STREAMER_MACROS_SVH
`define OLED_PAGE_FRAME_STREAMER_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising clk_i edge outside reset.
`define ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_IMPL(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/opfs_pkg.sv
package opfs_pkg;

  localparam int unsigned DEF_FRAME_WIDTH = 128;
  localparam int unsigned DEF_PAGE_COUNT  = 8;

  // Fixed field widths
  localparam int unsigned IN_W        = 16;
  localparam int unsigned COL_OFS_W   = 7;
  localparam int unsigned FULL_ADDR_W = 11;

  localparam int unsigned INIT_LEN   = 23;
  localparam int unsigned INIT_IDX_W = 5;

  localparam logic [7:0] PREFIX_CMD    = 8'h00;
  localparam logic [7:0] PREFIX_DATA   = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] COL_OFS_RESET = 8'h02;

  typedef enum logic [1:0] {
    OP_WRITE_PIXEL = 2'd0,
    OP_REFRESH     = 2'd1,
    OP_INIT        = 2'd2,
    OP_PULL        = 2'd3
  } opcode_e;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_pull;
    logic out_blocked;
  } dp_sts_t;

  function automatic logic [7:0] init_rom_byte(input logic [INIT_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'hAE;
      5'd1:    b = 8'hD5;
      5'd2:    b = 8'h80;
      5'd3:    b = 8'hA8;
      5'd4:    b = 8'h3F;
      5'd5:    b = 8'hD3;
      5'd6:    b = 8'h00;
      5'd7:    b = 8'h40;
      5'd8:    b = 8'h8D;
      5'd9:    b = 8'h14;
      5'd10:   b = 8'hA1;
      5'd11:   b = 8'hC8;
      5'd12:   b = 8'hDA;
      5'd13:   b = 8'h12;
      5'd14:   b = 8'h81;
      5'd15:   b = 8'hCF;
      5'd16:   b = 8'hD9;
      5'd17:   b = 8'hF1;
      5'd18:   b = 8'hDB;
      5'd19:   b = 8'h40;
      5'd20:   b = 8'hA4;
      5'd21:   b = 8'hA6;
      5'd22:   b = 8'hAF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/opfs_ctrl.sv
`include "oled_page_frame_streamer_macros.svh"

module opfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  opfs_pkg::dp_sts_t sts_i,
  output opfs_pkg::dp_cmd_t cmd_o
);
  import opfs_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    s_tready_o     = 1'b0;
    cmd_o.clear_en = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.exec     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a pull waits for room in the output register
        if (!(sts_i.op_pull && sts_i.out_blocked)) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEVER(a_no_accept_in_clear, state_q == ST_CLEAR && s_tready_o, "ready during clear")
  `ASSERT_IMPL(a_accept_then_exec, cmd_o.accept |=> state_q == ST_EXEC, "accept not followed by exec")
  `ASSERT_IMPL(a_pull_has_room, cmd_o.exec && sts_i.op_pull |-> !sts_i.out_blocked, "pull into full output")

endmodule

FILE: rtl/opfs_datapath.sv
`include "oled_page_frame_streamer_macros.svh"

module opfs_datapath #(
  parameter int unsigned FRAME_WIDTH = opfs_pkg::DEF_FRAME_WIDTH,
  parameter int unsigned PAGE_COUNT  = opfs_pkg::DEF_PAGE_COUNT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  opfs_pkg::dp_cmd_t              cmd_i,
  output opfs_pkg::dp_sts_t              sts_o,
  input  logic [opfs_pkg::IN_W-1:0]      in_data_i,
  input  logic                           cfg_valid_i,
  input  logic [opfs_pkg::COL_OFS_W-1:0] cfg_data_i,
  input  logic                           m_tready_i,
  output logic                           m_tvalid_o,
  output logic [7:0]                     m_tdata_o,
  output logic                           m_tlast_o,
  output logic [1:0]                     m_tuser_o
);
  import opfs_pkg::*;

  localparam int unsigned DEPTH  = FRAME_WIDTH * PAGE_COUNT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned COL_W  = $clog2(FRAME_WIDTH);
  localparam int unsigned PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_INIT_PRE = 3'd1;
  localparam logic [2:0] PH_INIT_CMD = 3'd2;
  localparam logic [2:0] PH_CMD_PRE  = 3'd3;
  localparam logic [2:0] PH_CMD_BYTE = 3'd4;
  localparam logic [2:0] PH_DATA_PRE = 3'd5;
  localparam logic [2:0] PH_DATA     = 3'd6;

  // input word unpack
  opcode_e    in_op;
  logic [6:0] in_x;
  logic [5:0] in_y;
  logic       in_on;
  assign in_op = opcode_e'(in_data_i[1:0]);
  assign in_x  = in_data_i[8:2];
  assign in_y  = in_data_i[14:9];
  assign in_on = in_data_i[15];

  // sequencer
  logic [2:0]            phase_q, phase_d;
  logic [PAGE_W-1:0]     page_q, page_d;
  logic [COL_W-1:0]      byte_q, byte_d;
  logic [INIT_IDX_W-1:0] init_q, init_d;
  logic [COL_OFS_W-1:0]  col_q;

  // latched item
  opcode_e           op_q;
  logic              pix_ok_q;
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        bit_q;
  logic              on_q;

  // frame RAM
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr, clr_q;
  logic [7:0]        wr_data, bit_mask;

  logic [FULL_ADDR_W-1:0] pix_addr_full, seq_addr_full;
  logic                   pix_ok;

  // output register
  logic       out_load;
  logic [7:0] out_byte_d, out_byte_q;
  logic       out_valid_d, out_valid_q;
  logic       out_first_d, out_first_q;
  logic       out_last_d, out_last_q;
  logic       m_tvalid_q;

  assign pix_addr_full = FULL_ADDR_W'(in_y[5:3]) * FULL_ADDR_W'(FRAME_WIDTH)
                       + FULL_ADDR_W'(in_x);
  assign seq_addr_full = FULL_ADDR_W'(page_q) * FULL_ADDR_W'(FRAME_WIDTH)
                       + FULL_ADDR_W'(byte_q);
  assign pix_ok = ({1'b0, in_x} < 8'(FRAME_WIDTH)) && ({1'b0, in_y} < 7'(PAGE_COUNT * 8));

  assign rd_en   = cmd_i.accept;
  assign rd_addr = (in_op == OP_PULL) ? seq_addr_full[ADDR_W-1:0]
                                      : pix_addr_full[ADDR_W-1:0];

  assign bit_mask = 8'(1) << bit_q;
  assign wr_en    = cmd_i.clear_en
                  || (cmd_i.exec && op_q == OP_WRITE_PIXEL && pix_ok_q);
  assign wr_addr  = cmd_i.clear_en ? clr_q : addr_q;
  assign wr_data  = cmd_i.clear_en ? 8'h00
                  : (on_q ? (rd_data_q | bit_mask) : (rd_data_q & ~bit_mask));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= in_op;
      pix_ok_q <= pix_ok;
      addr_q   <= pix_addr_full[ADDR_W-1:0];
      bit_q    <= in_y[2:0];
      on_q     <= in_on;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    page_d      = page_q;
    byte_d      = byte_q;
    init_d      = init_q;
    out_load    = 1'b0;
    out_byte_d  = 8'h00;
    out_valid_d = 1'b0;
    out_first_d = 1'b0;
    out_last_d  = 1'b0;
    if (cmd_i.exec) begin
      unique case (op_q)
        OP_WRITE_PIXEL: ;
        OP_REFRESH: begin
          if (phase_q == PH_IDLE) begin
            page_d  = '0;
            byte_d  = '0;
            phase_d = PH_CMD_PRE;
          end
        end
        OP_INIT: begin
          if (phase_q == PH_IDLE) begin
            init_d  = '0;
            page_d  = '0;
            byte_d  = '0;
            phase_d = PH_INIT_PRE;
          end
        end
        OP_PULL: begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          unique case (phase_q)
            PH_INIT_PRE: begin
              out_byte_d  = PREFIX_CMD;
              out_first_d = 1'b1;
              phase_d     = PH_INIT_CMD;
            end
            PH_INIT_CMD: begin
              out_byte_d = init_rom_byte(init_q);
              out_last_d = 1'b1;
              if (init_q == INIT_IDX_W'(INIT_LEN - 1)) begin
                init_d  = '0;
                page_d  = '0;
                byte_d  = '0;
                phase_d = PH_CMD_PRE;
              end else begin
                init_d  = init_q + INIT_IDX_W'(1);
                phase_d = PH_INIT_PRE;
              end
            end
            PH_CMD_PRE: begin
              out_byte_d  = PREFIX_CMD;
              out_first_d = 1'b1;
              phase_d     = PH_CMD_BYTE;
            end
            PH_CMD_BYTE: begin
              out_last_d = 1'b1;
              if (byte_q == COL_W'(0)) begin
                out_byte_d = CMD_PAGE_BASE + 8'(page_q);
              end else if (byte_q == COL_W'(1)) begin
                out_byte_d = {4'h0, col_q[3:0]};
              end else begin
                out_byte_d = CMD_COL_HIGH | {5'b0, col_q[6:4]};
              end
              if (byte_q == COL_W'(2)) begin
                byte_d  = '0;
                phase_d = PH_DATA_PRE;
              end else begin
                byte_d  = byte_q + COL_W'(1);
                phase_d = PH_CMD_PRE;
              end
            end
            PH_DATA_PRE: begin
              out_byte_d  = PREFIX_DATA;
              out_first_d = 1'b1;
              phase_d     = PH_DATA;
            end
            PH_DATA: begin
              out_byte_d = rd_data_q;
              if (byte_q == COL_W'(FRAME_WIDTH - 1)) begin
                out_last_d = 1'b1;
                byte_d     = '0;
                if (page_q == PAGE_W'(PAGE_COUNT - 1)) begin
                  page_d  = '0;
                  phase_d = PH_IDLE;
                end else begin
                  page_d  = page_q + PAGE_W'(1);
                  phase_d = PH_CMD_PRE;
                end
              end else begin
                byte_d = byte_q + COL_W'(1);
              end
            end
            default: begin
              // idle: empty word
              out_valid_d = 1'b0;
              phase_d     = PH_IDLE;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      page_q     <= '0;
      byte_q     <= '0;
      init_q     <= '0;
      col_q      <= COL_OFS_RESET[COL_OFS_W-1:0];
      m_tvalid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      page_q  <= page_d;
      byte_q  <= byte_d;
      init_q  <= init_d;
      if (cfg_valid_i) col_q <= cfg_data_i;
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q  <= out_byte_d;
      out_valid_q <= out_valid_d;
      out_first_q <= out_first_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = out_byte_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = {out_first_q, out_valid_q};

  assign sts_o.clear_last  = (clr_q == ADDR_W'(DEPTH - 1));
  assign sts_o.op_pull     = (op_q == OP_PULL);
  assign sts_o.out_blocked = m_tvalid_q && !m_tready_i;

  `ASSERT_NEVER(a_ram_one_port_op, wr_en && rd_en, "frame RAM read and write together")
  `ASSERT_NEVER(a_out_overwrite, out_load && m_tvalid_q && !m_tready_i, "output word overwritten")
  `ASSERT_NEVER(a_page_range, page_q > PAGE_W'(PAGE_COUNT - 1), "page index out of range")

endmodule

FILE: rtl/oled_page_frame_streamer.sv
// Page-mode OLED frame streamer. Holds a FRAME_WIDTH x (8*PAGE_COUNT) one-bit
// frame in an on-chip RAM, page-major (bit y%8 of byte page*FRAME_WIDTH+x,
// LSB = top row), and turns it into the byte stream for a page-mode display
// controller. Each input word carries an opcode: write pixel, start refresh,
// start init (23-byte command ROM, then a refresh) or pull. Only a pull gives
// an output word: the next link byte with a valid flag (clear when the
// sequencer is idle), a transfer-first flag on control prefixes and tlast on
// the final byte of each transfer. A refresh sends per page three command
// transfers (page address, column low nibble, column high nibble taken from
// the column offset register) then a data transfer of FRAME_WIDTH bytes; data
// is read from the frame when pulled. Starts while busy are dropped, pixels
// out of range are dropped. After reset the frame RAM is cleared one entry a
// cycle, all FRAME_WIDTH*PAGE_COUNT entries (1024 by default), with
// s_axis_tready low. Each input word is then accepted in the idle state,
// using the single RAM read port, and executed in the exec state, which does
// the write-back of the pixel read-modify-write or loads the output register.
// A pull waits in the exec state while the output register holds an untaken
// word. The column offset port is always ready; write it only while idle.
module oled_page_frame_streamer #(
  parameter int unsigned FRAME_WIDTH = opfs_pkg::DEF_FRAME_WIDTH,
  parameter int unsigned PAGE_COUNT  = opfs_pkg::DEF_PAGE_COUNT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command words
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [opfs_pkg::IN_W-1:0]      s_axis_tdata_i,  // opcode[1:0], pixel_x[8:2],
                                                          // pixel_y[14:9], pixel_on[15]
  // link bytes
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,  // link_byte[7:0]
  output logic                           m_axis_tlast_o,  // transfer_last
  output logic [1:0]                     m_axis_tuser_o,  // byte_valid[0], transfer_first[1]
  // column offset register
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [opfs_pkg::COL_OFS_W-1:0] cfg_data_i
);
  import opfs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // handshake and RAM clear sequencing
  opfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // frame RAM, byte sequencer and output register
  opfs_datapath #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule
